>>> rtl/mfh_pkg.sv
// ---------------------------------------------------------------------------
// mfh_pkg: shared types and codes of the mutex with a FIFO wait queue
// Holds the request and result item types, the operation codes, the status
// codes and the type of one wait queue entry.
// ---------------------------------------------------------------------------
package mfh_pkg;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_FREED    = 3'd2,
    ST_HANDOFF  = 3'd3,
    ST_REJECTED = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned WAITERS_W = 5;

  typedef struct packed {
    op_t               operation;
    logic [SLOT_W-1:0] task_slot;
    logic [ID_W-1:0]   task_id;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 wake_valid;
    logic [SLOT_W-1:0]    wake_slot;
    logic                 is_locked;
    logic [ID_W-1:0]      holder_id;
    logic [WAITERS_W-1:0] waiters;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] task_slot;
    logic [ID_W-1:0]   task_id;
  } q_entry_t;

  localparam int unsigned Q_ENTRY_W = $bits(q_entry_t);

endpackage

>>> rtl/mfh_wait_ram.sv
// ---------------------------------------------------------------------------
// mfh_wait_ram: wait queue storage
// Simple dual-port memory with one write port and one read port whose data
// is registered.
// ---------------------------------------------------------------------------
module mfh_wait_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mutex_fifo_handoff.sv
// ---------------------------------------------------------------------------
// mutex_fifo_handoff: hardware mutex with a FIFO of blocked tasks
// Grants, queues, hands off, frees, rejects or reports full for each lock or
// unlock item and returns one result item per request.
//
//   Channel  Ports                        Direction  Carries
//   in       in_valid, in_ready, in_data  input      request item (in_item_t)
//   out      out_valid, out_ready, out_data output   result item (out_item_t)
//
// Each item is handled in two steps: on accept the wait RAM reads the head
// entry, and the execute state then uses the registered read data; no new
// request is taken until the execute state is done.
// Reset is synchronous and clears the mutex, pointers and count; the wait
// RAM is not cleared, since an entry is only used after it was written.
// A result that has not been taken holds off the next request.
// ---------------------------------------------------------------------------
module mutex_fifo_handoff
  import mfh_pkg::*;
#(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned PW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(MAX_WAITERS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_WAITERS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        req_r;
  logic            held_r, held_nxt;
  logic [ID_W-1:0] owner_r, owner_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            wr_en;
  q_entry_t        wr_entry;
  q_entry_t        rd_entry;
  logic            in_fire;

  mfh_wait_ram #(
    .DEPTH (MAX_WAITERS),
    .WIDTH (Q_ENTRY_W)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_r),
    .rd_data (rd_entry)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_entry.task_slot = req_r.task_slot;
  assign wr_entry.task_id   = req_r.task_id;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    owner_nxt     = owner_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt               = S_IDLE;
        out_data_nxt.wake_valid = 1'b0;
        out_data_nxt.wake_slot  = '0;
        if (req_r.operation == OP_LOCK) begin
          if (!held_r) begin
            held_nxt            = 1'b1;
            owner_nxt           = req_r.task_id;
            out_data_nxt.status = ST_GRANTED;
          end else if (count_r == FULL_CNT) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            wr_en               = 1'b1;
            tail_nxt            = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
            count_nxt           = count_r + 1'b1;
            out_data_nxt.status = ST_BLOCKED;
          end
        end else begin
          if (!held_r || (owner_r != req_r.task_id)) begin
            out_data_nxt.status = ST_REJECTED;
          end else if (count_r != '0) begin
            owner_nxt               = rd_entry.task_id;
            head_nxt                = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
            count_nxt               = count_r - 1'b1;
            out_data_nxt.wake_valid = 1'b1;
            out_data_nxt.wake_slot  = rd_entry.task_slot;
            out_data_nxt.status     = ST_HANDOFF;
          end else begin
            held_nxt            = 1'b0;
            out_data_nxt.status = ST_FREED;
          end
        end
        out_data_nxt.is_locked = held_nxt;
        out_data_nxt.holder_id = held_nxt ? owner_nxt : '0;
        out_data_nxt.waiters   = WAITERS_W'(count_nxt);
        out_valid_nxt          = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      req_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      owner_r     <= owner_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (in_fire) begin
        req_r <= in_data;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("Wait count exceeds the queue depth.");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (count_r == '0))
    else $error("Tasks are queued on a free mutex.");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC) && !out_valid_r)
    else $error("An accepted item did not reach execution with a free output.");

  a_wake_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.wake_valid) |-> (out_data_r.status == ST_HANDOFF))
    else $error("A wake was reported without a handoff.");

endmodule
